### hdl/sqt_pkg.sv
// shared constants, types and symbol lookup for the radix text converter
package sqt_pkg;

    // field and storage sizes
    localparam int VALUE_W    = 32;
    localparam int SYM_W      = 8;
    localparam int NUM_SYMS   = 16;
    localparam int SYMS_W     = SYM_W * NUM_SYMS;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 32;
    localparam int STACK_W    = DIGIT_W * MAX_DIGITS;
    localparam int RADIX_W    = 5;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 6;
    localparam int MAX_RADIX  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd2;

    // reserved characters
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [RADIX_W-1:0] radix_t;

    // symbol idx of the packed alphabet
    function automatic sym_t sym_at(input logic [SYMS_W-1:0] syms, input digit_t idx);
        sym_at = syms[idx*SYM_W +: SYM_W];
    endfunction

endpackage

### hdl/sqt_alpha.sv
// alphabet check: radix range, reserved characters and duplicate symbols
module sqt_alpha
    import sqt_pkg::*;
(
    input  logic [SYMS_W-1:0] syms,
    input  radix_t            radix,
    output logic              alpha_ok
);

    logic bad_sym;
    logic dup_sym;
    logic radix_ok;

    // range of the symbol count
    assign radix_ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));

    // reserved characters among the used symbols
    always_comb
    begin
        bad_sym = 1'b0;
        for (int i = 0; i < NUM_SYMS; i++)
        begin
            if ((RADIX_W'(i) < radix) &&
                ((sym_at(syms, DIGIT_W'(i)) == CHAR_PLUS) ||
                 (sym_at(syms, DIGIT_W'(i)) == CHAR_MINUS)))
            begin
                bad_sym = 1'b1;
            end
        end
    end

    // pairwise compare of the used symbols
    always_comb
    begin
        dup_sym = 1'b0;
        for (int i = 0; i < NUM_SYMS; i++)
        begin
            for (int j = i + 1; j < NUM_SYMS; j++)
            begin
                if ((RADIX_W'(j) < radix) &&
                    (sym_at(syms, DIGIT_W'(i)) == sym_at(syms, DIGIT_W'(j))))
                begin
                    dup_sym = 1'b1;
                end
            end
        end
    end

    assign alpha_ok = radix_ok && !bad_sym && !dup_sym;

endmodule

### hdl/sqt_divstep.sv
// shared divide unit: eight restoring steps of a byte by the radix
module sqt_divstep
    import sqt_pkg::*;
(
    input  digit_t       rem_in,
    input  logic [7:0]   byte_in,
    input  radix_t       base,
    output logic [7:0]   quot,
    output digit_t       rem_out
);

    logic [RADIX_W-1:0] r;
    logic [RADIX_W-1:0] t;

    // long division, one quotient bit per step, msb first
    always_comb
    begin
        r    = {1'b0, rem_in};
        t    = '0;
        quot = '0;
        for (int b = 7; b >= 0; b--)
        begin
            t = {r[DIGIT_W-1:0], byte_in[b]};
            if (t >= base)
            begin
                r       = t - base;
                quot[b] = 1'b1;
            end
            else
            begin
                r = t;
            end
        end
        rem_out = r[DIGIT_W-1:0];
    end

endmodule

### hdl/signed_int_to_radix_text.sv
// signed 32-bit value to text in a configured radix, one character per word
// operation: a value is taken in idle, each digit takes one pass through the shared divide
// unit per byte of the quotient, then the characters go one at a time into the output register
// as the output slot frees; the block takes no new value until the last character of the
// current one is loaded
// reset: asynchronous active low, clears control and config registers (invalid alphabet)
module signed_int_to_radix_text
    import sqt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SYM_W-1:0]     out_char,
    output logic                 last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [CFG_W-1:0]   sym_low_reg;
    logic [CFG_W-1:0]   sym_high_reg;
    radix_t             radix_reg;
    logic [SYMS_W-1:0]  syms;
    logic               alpha_ok;

    logic [1:0]         state_reg, state_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    digit_t             rem_reg, rem_next;
    logic [1:0]         byte_cnt_reg, byte_cnt_next;
    logic [CNT_W-1:0]   nd_reg, nd_next;
    logic [STACK_W-1:0] stack_reg, stack_next;
    logic               minus_reg, minus_next;
    radix_t             base_reg, base_next;

    logic               out_valid_reg, out_valid_next;
    sym_t               out_char_reg, out_char_next;
    logic               last_reg, last_next;

    logic [7:0]         quot;
    digit_t             div_rem;
    logic [VALUE_W-1:0] quot_full;
    logic               slot_free;
    logic [VALUE_W-1:0] raw;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
            radix_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SYMBOLS_LOW:  sym_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: sym_high_reg <= cfg_data;
                REG_RADIX:        radix_reg    <= cfg_data[RADIX_W-1:0];
                default:          ;
            endcase
        end
    end

    assign syms = {sym_high_reg, sym_low_reg};

    sqt_alpha u_alpha
    (
        .syms     (syms),
        .radix    (radix_reg),
        .alpha_ok (alpha_ok)
    );

    sqt_divstep u_divstep
    (
        .rem_in  (rem_reg),
        .byte_in (mag_reg[VALUE_W-1 -: 8]),
        .base    (base_reg),
        .quot    (quot),
        .rem_out (div_rem)
    );

    assign quot_full = {mag_reg[VALUE_W-9:0], quot};
    assign slot_free = !out_valid_reg || out_ready;
    assign raw       = $unsigned(value);

    // sequencer: divide passes, then characters from the digit stack
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        byte_cnt_next  = byte_cnt_reg;
        nd_next        = nd_reg;
        stack_next     = stack_reg;
        minus_next     = minus_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && alpha_ok)
                begin
                    minus_next    = raw[VALUE_W-1];
                    mag_next      = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
                    base_next     = radix_reg;
                    rem_next      = '0;
                    byte_cnt_next = '0;
                    nd_next       = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                mag_next      = quot_full;
                rem_next      = div_rem;
                byte_cnt_next = byte_cnt_reg + 2'd1;
                // a full quotient yields one digit
                if (byte_cnt_reg == 2'd3)
                begin
                    stack_next = {div_rem, stack_reg[STACK_W-1:DIGIT_W]};
                    nd_next    = nd_reg + CNT_W'(1);
                    rem_next   = '0;
                    if ((quot_full == '0) || (nd_reg == CNT_W'(MAX_DIGITS - 1)))
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (minus_reg)
                    begin
                        out_char_next = CHAR_MINUS;
                        last_next     = 1'b0;
                        minus_next    = 1'b0;
                    end
                    else
                    begin
                        out_char_next = sym_at(syms, stack_reg[STACK_W-1 -: DIGIT_W]);
                        last_next     = (nd_reg == CNT_W'(1));
                        stack_next    = {stack_reg[STACK_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        nd_next       = nd_reg - CNT_W'(1);
                        if (nd_reg == CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_cnt_reg  <= '0;
            nd_reg        <= '0;
            minus_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            nd_reg        <= nd_next;
            minus_reg     <= minus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        stack_reg    <= stack_next;
        base_reg     <= base_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    // running remainder stays below the radix
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < base_reg))
        else $error("remainder not below radix");

    // emitting only with digits left on the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (nd_reg != '0))
        else $error("emit with empty digit stack");

    // digit count bounded
    assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count overflow");

    // a final character is loaded together with the return to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg && !$stable(out_char_reg)) |-> (state_reg == ST_IDLE))
        else $error("last character loaded while still busy");

    // the minus sign goes out before any digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && minus_reg && slot_free) |=> (out_char_reg == CHAR_MINUS))
        else $error("minus sign not first");

endmodule

### dv/tb_top.sv
// testbench for the signed integer to radix text converter
`timescale 1ns / 1ps

module tb_top
    import sqt_pkg::*;
();

    // settle time after the last character, covers a radix 2 conversion of 32 digits
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 420;
    localparam int CALM_FROM      = 360;
    localparam int MAX_REPORTS    = 10;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // decimal and hexadecimal alphabets, symbol 0 in the low byte
    localparam logic [CFG_W-1:0] DEC_LOW  = 64'h3736353433323130;
    localparam logic [CFG_W-1:0] DEC_HIGH = 64'h0000000000003938;
    localparam logic [CFG_W-1:0] HEX_HIGH = 64'h6665646362613938;
    // zero byte and all-ones byte used as ordinary symbols
    localparam logic [CFG_W-1:0] ODD_LOW  = 64'h4746454443424100;
    localparam logic [CFG_W-1:0] ODD_HIGH = 64'h4E4D4C4B4A4948FF;
    // radix 3, reserved and repeated bytes only in the unused slots
    localparam logic [CFG_W-1:0] TRI_LOW  = 64'h7830302D2B323130;

    typedef struct packed {
        sym_t ch;
        logic is_last;
    } text_char_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]            cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic signed [VALUE_W-1:0]   value     = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [SYM_W-1:0]            out_char;
    logic                        last;

    // alphabet as the converter should hold it
    logic [CFG_W-1:0] sym_lo    = '0;
    logic [CFG_W-1:0] sym_hi    = '0;
    radix_t           radix_cfg = '0;

    logic signed [VALUE_W-1:0] pending_values [$];
    text_char_t                text_due [$];
    text_char_t                due_char;

    int  values_queued  = 0;
    int  values_taken   = 0;
    int  random_items   = 0;
    int  chars_checked  = 0;
    int  alphabets_used = 0;
    int  mismatches     = 0;
    int  send_gap       = 0;
    int  ready_gap      = 0;
    int  idle_cycles    = 0;
    bit  calm           = 1'b0;

    signed_int_to_radix_text i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // symbol for a digit, low register holds symbols 0 to 7
    function automatic sym_t symbol_of(input int unsigned idx);
        logic [2*CFG_W-1:0] both;
        both = {sym_hi, sym_lo};
        return both[(idx % NUM_SYMS) * SYM_W +: SYM_W];
    endfunction

    // used symbols must be distinct and neither sign character
    function automatic bit alphabet_ok();
        int unsigned n;
        bit          ok;
        n  = radix_cfg;
        ok = (n >= 2) && (n <= MAX_RADIX);
        for (int i = 0; ok && i < n; i++)
        begin
            if (symbol_of(i) == CHAR_PLUS || symbol_of(i) == CHAR_MINUS)
                ok = 1'b0;
            for (int j = i + 1; j < n; j++)
                if (symbol_of(j) == symbol_of(i))
                    ok = 1'b0;
        end
        return ok;
    endfunction

    // characters the converter should emit for one value
    function automatic void spell_value(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        digit_t             digs [MAX_DIGITS];
        int                 nd;
        text_char_t         c;
        if (!alphabet_ok())
            return;
        mag = v;
        if (v[VALUE_W-1])
            mag = -mag;
        nd = 0;
        do
        begin
            digs[nd] = digit_t'(mag % radix_cfg);
            nd++;
            mag = mag / radix_cfg;
        end
        while (mag != 0 && nd < MAX_DIGITS);
        if (v[VALUE_W-1])
        begin
            c.ch      = CHAR_MINUS;
            c.is_last = 1'b0;
            text_due.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            c.ch      = symbol_of(digs[k]);
            c.is_last = (k == 0);
            text_due.push_back(c);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return 32'd0 - $urandom_range(1, 20);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            4: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            default: return $urandom();
        endcase
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // single register write, the model copy follows at the write edge
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SYMBOLS_LOW:  sym_lo    = data;
            REG_SYMBOLS_HIGH: sym_hi    = data;
            REG_RADIX:        radix_cfg = data[RADIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_alphabet(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                 input logic [CFG_W-1:0] radix_word);
        set_reg(REG_SYMBOLS_LOW, lo);
        set_reg(REG_SYMBOLS_HIGH, hi);
        set_reg(REG_RADIX, radix_word);
        alphabets_used++;
    endtask

    task automatic feed(input logic signed [VALUE_W-1:0] v);
        pending_values.push_back(v);
        values_queued++;
    endtask

    // sender holds off until every word has gone and the block is quiet again
    task automatic settle();
        while (!(values_taken == values_queued && text_due.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random alphabet, mostly well formed, sometimes broken on purpose
    task automatic random_alphabet();
        sym_t             s [NUM_SYMS];
        int unsigned      r;
        int unsigned      a;
        int unsigned      b;
        bit               clash;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] radix_word;
        r = $urandom_range(2, MAX_RADIX);
        for (int i = 0; i < NUM_SYMS; i++)
        begin
            clash = 1'b1;
            while (clash)
            begin
                s[i]  = sym_t'($urandom_range(0, 255));
                clash = 1'b0;
                if (i < r)
                begin
                    if (s[i] == CHAR_PLUS || s[i] == CHAR_MINUS)
                        clash = 1'b1;
                    for (int j = 0; j < i; j++)
                        if (s[j] == s[i])
                            clash = 1'b1;
                end
            end
        end
        case ($urandom_range(0, 9))
            0: s[$urandom_range(0, r - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
            1:
            begin
                a    = $urandom_range(0, r - 2);
                b    = $urandom_range(a + 1, r - 1);
                s[b] = s[a];
            end
            2: r = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            default: ;
        endcase
        for (int i = 0; i < NUM_SYMS / 2; i++)
        begin
            lo[i*SYM_W +: SYM_W] = s[i];
            hi[i*SYM_W +: SYM_W] = s[i + NUM_SYMS / 2];
        end
        // upper bits of the radix word are don't care
        radix_word = {$urandom(), $urandom()};
        radix_word[RADIX_W-1:0] = r[RADIX_W-1:0];
        load_alphabet(lo, hi, radix_word);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                spell_value(value);
                values_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_values.size() != 0)
                begin
                    if (!calm && $urandom_range(0, 5) == 0)
                    begin
                        send_gap <= $urandom_range(0, 5);
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        value    <= pending_values.pop_front();
                        in_valid <= 1'b1;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor and ready stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                chars_checked++;
                if (text_due.size() == 0)
                    flag_error($sformatf("unexpected word char %h last %b", out_char, last));
                else
                begin
                    due_char = text_due.pop_front();
                    if (out_char !== due_char.ch || last !== due_char.is_last)
                        flag_error($sformatf("char %h last %b, expected char %h last %b",
                                             out_char, last, due_char.ch, due_char.is_last));
                end
            end
            if (ready_gap > 0)
            begin
                ready_gap <= ready_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                ready_gap <= $urandom_range(0, 5);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake and no register write
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d quiet cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset alphabet is invalid, nothing comes out
        feed(5);
        feed(-5);
        settle();

        // decimal, field extremes and sign handling
        load_alphabet(DEC_LOW, DEC_HIGH, 64'd10);
        feed(0);
        feed(1);
        feed(-1);
        feed(9);
        feed(10);
        feed(-10);
        feed(32'h7FFF_FFFF);
        feed(32'h8000_0000);
        feed(1000000000);
        feed(-99);
        settle();

        // binary, the most negative value gives the longest text
        load_alphabet(DEC_LOW, DEC_HIGH, 64'd2);
        feed(32'h8000_0000);
        feed(32'h7FFF_FFFF);
        feed(0);
        feed(-1);
        settle();

        // full radix with zero and all-ones bytes as digits
        load_alphabet(ODD_LOW, ODD_HIGH, 64'd16);
        feed(32'h8000_0000);
        feed(32'h7FFF_FFFF);
        feed(0);
        feed(32'hDEAD_BEEF);
        feed(-16);
        settle();

        // reserved and repeated bytes outside the used range are harmless
        load_alphabet(TRI_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
        feed(-7);
        feed(26);
        settle();

        // broken alphabets: radix too small or too large, sign or repeat in use
        load_alphabet(DEC_LOW, HEX_HIGH, 64'd1);
        feed(3);
        settle();
        load_alphabet(DEC_LOW, HEX_HIGH, 64'd17);
        feed(-3);
        settle();
        load_alphabet(DEC_LOW, HEX_HIGH, {59'h7FF_FFFF_FFFF_FFFF, 5'd31});
        feed(12);
        settle();
        load_alphabet((DEC_LOW & ~(64'hFF << 24)) | (64'(CHAR_PLUS) << 24), DEC_HIGH, 64'd10);
        feed(44);
        settle();
        load_alphabet((DEC_LOW & ~(64'hFF << 40)) | (64'(CHAR_MINUS) << 40), DEC_HIGH, 64'd10);
        feed(-44);
        settle();
        // symbol 8 repeats symbol 0
        load_alphabet(DEC_LOW, (HEX_HIGH & ~64'hFF) | 64'h30, 64'd16);
        feed(255);
        settle();

        // hex, plus a write to the spare index that must change nothing
        load_alphabet(DEC_LOW, HEX_HIGH, 64'd16);
        set_reg(REG_SPARE, {$urandom(), $urandom()});
        feed(32'hCAFE_F00D);
        feed(-255);
        settle();

        // random alphabets with random values, quiet handshakes towards the end
        while (random_items < RANDOM_ITEMS)
        begin
            random_alphabet();
            calm = (random_items >= CALM_FROM);
            for (int i = 0; i < 30; i++)
            begin
                feed(pick_value());
                random_items++;
            end
            settle();
        end

        $display("Converted %0d values into %0d characters over %0d alphabets",
                 values_queued, chars_checked, alphabets_used);
        $display("Radix 2 to 16, broken alphabets and sign extremes included");
        if (mismatches == 0 && text_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
hdl/sqt_pkg.sv
hdl/sqt_alpha.sv
hdl/sqt_divstep.sv
hdl/signed_int_to_radix_text.sv
dv/tb_top.sv
